/* rtl/gclu_pkg.sv */
package gclu_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int LCM_BITS     = 2 * OPERAND_BITS;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS + 1);

    typedef struct packed {
        logic [OPERAND_BITS-1:0] first_operand;
        logic [OPERAND_BITS-1:0] second_operand;
    } gclu_req_t;

    typedef struct packed {
        logic [OPERAND_BITS-1:0] gcd_value;
        logic [LCM_BITS-1:0]     lcm_value;
        logic                    both_zero;
    } gclu_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL
    } gclu_state_t;

endpackage

/* rtl/gcd_lcm_unit_core.sv */
// Channel | Direction | Handshake        | Word
// req     | in        | req_valid/stall  | first_operand, second_operand
// rsp     | out       | rsp_valid/stall  | gcd_value, lcm_value, both_zero
//
// One word at a time: accept, binary gcd steps, divide steps, then multiply.
// The subtractor is shared; it serves both gcd and divide.
// A zero operand skips gcd and divide.
// rst_n clears the sequencer and the result valid at once.
// A stalled result holds in the output register; the next word may enter.
module gcd_lcm_unit_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  gclu_pkg::gclu_req_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output gclu_pkg::gclu_rsp_t rsp_data
);
    import gclu_pkg::*;

    localparam int W = OPERAND_BITS;

    gclu_state_t         state_reg, state_next;
    logic [W-1:0]        u_reg, u_next;
    logic [W-1:0]        v_reg, v_next;
    logic [CNT_BITS-1:0] k_reg, k_next;
    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        b_reg, b_next;
    logic [W-1:0]        g_reg, g_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                zero_reg, zero_next;
    gclu_rsp_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                accept;
    logic                load_out;
    logic                u_lt_v;
    logic                u_eq_v;
    logic [W:0]          sub_x;
    logic [W:0]          sub_y;
    logic [W+1:0]        diff;
    logic                borrow;
    logic [LCM_BITS-1:0] product;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;
    assign load_out  = (state_reg == ST_MUL) && (!out_valid_reg || !rsp_stall);

    assign u_lt_v = (u_reg < v_reg);
    assign u_eq_v = (u_reg == v_reg);

    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            sub_x = {rem_reg, a_reg[W-1]};
            sub_y = {1'b0, g_reg};
        end
        else
        begin
            sub_x = {1'b0, u_lt_v ? v_reg : u_reg};
            sub_y = {1'b0, u_lt_v ? u_reg : v_reg};
        end
    end

    assign diff    = {1'b0, sub_x} - {1'b0, sub_y};
    assign borrow  = diff[W+1];
    assign product = LCM_BITS'(a_reg) * LCM_BITS'(b_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req_data.first_operand == '0) || (req_data.second_operand == '0))
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                if (u_eq_v)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_BITS'(1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        u_next         = u_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        g_next         = g_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        zero_next      = zero_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    u_next    = req_data.first_operand;
                    v_next    = req_data.second_operand;
                    k_next    = '0;
                    b_next    = req_data.second_operand;
                    g_next    = req_data.first_operand | req_data.second_operand;
                    zero_next = (req_data.first_operand == '0) &&
                                (req_data.second_operand == '0);
                    if ((req_data.first_operand == '0) || (req_data.second_operand == '0))
                    begin
                        a_next = '0;
                    end
                    else
                    begin
                        a_next = req_data.first_operand;
                    end
                end
            end
            ST_GCD:
            begin
                priority if (u_eq_v)
                begin
                    g_next   = u_reg << k_reg;
                    rem_next = '0;
                    cnt_next = CNT_BITS'(W);
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + CNT_BITS'(1);
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_lt_v)
                begin
                    v_next = diff[W-1:0];
                end
                else
                begin
                    u_next = diff[W-1:0];
                end
            end
            ST_DIV:
            begin
                rem_next = borrow ? sub_x[W-1:0] : diff[W-1:0];
                a_next   = {a_reg[W-2:0], ~borrow};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            ST_MUL:
            begin
                if (load_out)
                begin
                    out_next.gcd_value = g_reg;
                    out_next.lcm_value = product;
                    out_next.both_zero = zero_reg;
                    out_valid_next     = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        v_reg    <= v_next;
        k_reg    <= k_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
        out_reg  <= out_next;
    end

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD) |-> ((u_reg != '0) && (v_reg != '0)))
        else $error("gcd operand reached zero");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((g_reg != '0) && (rem_reg < g_reg)))
        else $error("divide by zero or remainder out of range");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.both_zero) |->
            ((rsp_data.gcd_value == '0) && (rsp_data.lcm_value == '0)))
        else $error("both-zero result not cleared");

    a_lcm_needs_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.lcm_value != '0)) |-> (rsp_data.gcd_value != '0))
        else $error("nonzero lcm with zero gcd");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_stall && (state_reg == ST_MUL)) |=> (state_reg == ST_MUL))
        else $error("sequencer left multiply while result stalled");

endmodule
